### design/cat_pkg.sv
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and constants of the compacting array table: command and
// status codes, field widths, the cell control bundle and the preset values.
// ----------------------------------------------------------------------------
`default_nettype none

package cat_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    localparam logic [CNT_W-1:0] PRESET_COUNT = 7'd6;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_MATCH    = 3'd5
    } t_status;

    // per-cell control from the sequencer
    typedef struct packed {
        logic wr;      // load the key into this cell
        logic shift;   // take the entry of the upper neighbor
        logic cap;     // capture the compare result
        logic hshift;  // take the hit flag of the upper neighbor
        logic live;    // cell index is below the fill count
    } t_cell_ctl;

    function automatic logic [DATA_W-1:0] preset_val(input int idx);
        logic [DATA_W-1:0] v;
        case (idx)
            0:       v = 32'd9;
            1:       v = 32'd0;
            2:       v = 32'd8;
            3:       v = 32'd3;
            4:       v = 32'd4;
            5:       v = 32'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/compacting_array_table.sv
// ----------------------------------------------------------------------------
// compacting_array_table
// Packed table of signed 32-bit entries with append, delete-first-match and
// search-all-matches commands, built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// append: the result is held in the result register, then moved to the output
//   register once the output slot is free
// delete/search: hit flags capture the compares on acceptance, then walk down
//   the cell chain one index per cycle unless a match waits for the output
// one item at a time; a finished result may wait in the output register
// synchronous active-low reset loads the six preset entries, fill count 6
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_array_table
    import cat_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [CMD_W-1:0]         i_cmd,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [2:0]                    o_status,
    output logic [IDX_W-1:0]              o_match_index,
    output logic [CNT_W-1:0]              o_fill_count,
    output logic                          o_last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEL,
        S_RESULT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [IW-1:0]      r_idx;
    logic [CMD_W-1:0]   r_cmd;
    t_status            r_res_status;
    logic [IDX_W-1:0]   r_res_idx;
    logic               r_ovalid;
    t_status            r_ostatus;
    logic [IDX_W-1:0]   r_oidx;
    logic [CNT_W-1:0]   r_ofill;
    logic               r_olast;

    logic                   w_acc;
    logic                   w_slot_free;
    logic                   w_full;
    logic                   w_any_hit;
    logic                   w_any_up;
    logic                   w_scan_emit;
    logic                   w_hshift;
    logic                   w_res_push;
    logic [DEPTH-1:0]       w_hit;
    logic [DEPTH-1:0]       w_live;
    logic [DATA_W-1:0]      w_entry [DEPTH];
    t_cell_ctl              w_ctl   [DEPTH];

    assign o_stall     = (r_state != S_IDLE);
    assign w_acc       = i_valid && !o_stall;
    assign w_slot_free = !r_ovalid || !i_stall;
    assign w_full      = (r_count >= CNT_W'(DEPTH));
    assign w_any_hit   = |w_hit;
    assign w_any_up    = |w_hit[DEPTH-1:1];

    assign w_scan_emit = (r_state == S_SCAN) && (r_cmd == CMD_SEARCH) && w_hit[0]
                         && w_slot_free;
    // advance the hit chain past a miss, or past a hit once it is emitted
    assign w_hshift    = (r_state == S_SCAN) && w_any_hit && (!w_hit[0] || w_scan_emit);
    assign w_res_push  = (r_state == S_RESULT) && w_slot_free;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_live[g]       = (CNT_W'(g) < r_count);
        assign w_ctl[g].wr     = w_acc && (i_cmd == CMD_APPEND) && !w_full
                                 && (CNT_W'(g) == r_count);
        assign w_ctl[g].shift  = (r_state == S_DEL) && (IW'(g) >= r_idx);
        assign w_ctl[g].cap    = w_acc && ((i_cmd == CMD_DELETE) || (i_cmd == CMD_SEARCH));
        assign w_ctl[g].hshift = w_hshift;
        assign w_ctl[g].live   = w_live[g];

        if (g == DEPTH - 1) begin : g_top
            cat_cell #(
                .RESET_VAL (preset_val(g))
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[g]),
                .i_key      (i_value),
                .i_up_entry ({DATA_W{1'b0}}),
                .i_up_hit   (1'b0),
                .o_entry    (w_entry[g]),
                .o_hit      (w_hit[g])
            );
        end else begin : g_mid
            cat_cell #(
                .RESET_VAL (preset_val(g))
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[g]),
                .i_key      (i_value),
                .i_up_entry (w_entry[g+1]),
                .i_up_hit   (w_hit[g+1]),
                .o_entry    (w_entry[g]),
                .o_hit      (w_hit[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= PRESET_COUNT;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        case (i_cmd)
                            CMD_APPEND: begin
                                if (w_full) begin
                                    r_res_status <= ST_FULL;
                                    r_res_idx    <= '0;
                                end else begin
                                    r_res_status <= ST_APPENDED;
                                    r_res_idx    <= r_count[IDX_W-1:0];
                                    r_count      <= r_count + 1'b1;
                                end
                                r_state <= S_RESULT;
                            end
                            CMD_DELETE, CMD_SEARCH: begin
                                if (r_count == '0) begin
                                    r_res_status <= ST_EMPTY;
                                    r_res_idx    <= '0;
                                    r_state      <= S_RESULT;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!w_any_hit) begin
                        r_res_status <= ST_NOTFOUND;
                        r_res_idx    <= '0;
                        r_state      <= S_RESULT;
                    end else if (w_hit[0]) begin
                        if (r_cmd == CMD_DELETE) begin
                            r_state <= S_DEL;
                        end else if (w_slot_free) begin
                            r_idx <= r_idx + 1'b1;
                            if (!w_any_up) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DEL: begin
                    r_count      <= r_count - 1'b1;
                    r_res_status <= ST_DELETED;
                    r_res_idx    <= IDX_W'(r_idx);
                    r_state      <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_scan_emit) begin
                r_ovalid  <= 1'b1;
                r_ostatus <= ST_MATCH;
                r_oidx    <= IDX_W'(r_idx);
                r_ofill   <= r_count;
                r_olast   <= !w_any_up;
            end else if (w_res_push) begin
                r_ovalid  <= 1'b1;
                r_ostatus <= r_res_status;
                r_oidx    <= r_res_idx;
                r_ofill   <= r_count;
                r_olast   <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_match_index = r_oidx;
    assign o_fill_count  = r_ofill;
    assign o_last        = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above table depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_cmd == CMD_APPEND) && !w_full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not grow the table");

    a_hits_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((w_hit & ~w_live) == '0))
        else $error("hit flag beyond the filled entries");

    a_del_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) |-> (CNT_W'(r_idx) < r_count))
        else $error("delete position beyond the filled entries");

endmodule

`default_nettype wire

### design/cat_cell.sv
// ----------------------------------------------------------------------------
// cat_cell
// One slot of the table: holds an entry and a hit flag, compares the entry
// with the key, and hands entry and hit down the chain on request.
// ----------------------------------------------------------------------------
`default_nettype none

module cat_cell
    import cat_pkg::*;
#(
    parameter logic [31:0] RESET_VAL = 32'd0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [DATA_W-1:0] i_key,
    input  wire logic [DATA_W-1:0] i_up_entry,
    input  wire logic              i_up_hit,
    output logic [DATA_W-1:0]      o_entry,
    output logic                   o_hit
);

    logic [DATA_W-1:0] r_entry;
    logic              r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= RESET_VAL;
            r_hit   <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_entry <= i_key;
            end else if (i_ctl.shift) begin
                r_entry <= i_up_entry;
            end
            if (i_ctl.cap) begin
                r_hit <= i_ctl.live && (r_entry == i_key);
            end else if (i_ctl.hshift) begin
                r_hit <= i_up_hit;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for compacting_array_table: drives append, delete and
// search transactions with random gaps and output back-pressure, and predicts
// every result from a shadow copy of the table kept in a scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import cat_pkg::*;

    localparam int TBL_DEPTH = 16;
    localparam int N_ITEMS   = 200;

    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] fill;
        logic             last;
    } t_result;

    class table_scoreboard;
        logic [DATA_W-1:0] entries [TBL_DEPTH];
        int unsigned       fill;
        t_result           pending_q [$];
        int                errors;

        function new();
            for (int i = 0; i < TBL_DEPTH; i++) begin
                entries[i] = preset_val(i);
            end
            fill   = PRESET_COUNT;
            errors = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void add_result(t_status st, int unsigned idx, int unsigned cnt, bit last_flag);
            t_result r;
            r.status = st;
            r.idx    = IDX_W'(idx);
            r.fill   = CNT_W'(cnt);
            r.last   = last_flag;
            pending_q = {pending_q, r};
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // update the shadow table and queue what the block must produce
        function void note_input(t_cmd cmd, logic [DATA_W-1:0] value);
            int pos;
            int hits;
            pos  = -1;
            hits = 0;
            case (cmd)
                CMD_APPEND: begin
                    if (fill >= TBL_DEPTH) begin
                        add_result(ST_FULL, 0, fill, 1'b1);
                    end else begin
                        entries[fill] = value;
                        fill++;
                        add_result(ST_APPENDED, fill - 1, fill, 1'b1);
                    end
                end
                CMD_DELETE: begin
                    if (fill == 0) begin
                        add_result(ST_EMPTY, 0, 0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            if (pos < 0 && entries[i] == value) pos = i;
                        end
                        if (pos < 0) begin
                            add_result(ST_NOTFOUND, 0, fill, 1'b1);
                        end else begin
                            for (int i = pos; i + 1 < fill; i++) begin
                                entries[i] = entries[i+1];
                            end
                            fill--;
                            entries[fill] = '0;
                            add_result(ST_DELETED, pos, fill, 1'b1);
                        end
                    end
                end
                CMD_SEARCH: begin
                    if (fill == 0) begin
                        add_result(ST_EMPTY, 0, 0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            if (entries[i] == value) begin
                                add_result(ST_MATCH, i, fill, 1'b0);
                                hits++;
                            end
                        end
                        if (hits == 0) begin
                            add_result(ST_NOTFOUND, 0, fill, 1'b1);
                        end else begin
                            pending_q[pending_q.size()-1].last = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task check_result(input logic [2:0] st, input logic [IDX_W-1:0] idx,
                          input logic [CNT_W-1:0] cnt, input logic last_flag);
            t_result r;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result status=%0d idx=%0d fill=%0d",
                                 st, idx, cnt));
            end else begin
                r = pending_q.pop_front();
                if (st !== r.status)
                    report($sformatf("status %0d, want %0d", st, r.status));
                if (idx !== r.idx)
                    report($sformatf("match_index %0d, want %0d", idx, r.idx));
                if (cnt !== r.fill)
                    report($sformatf("fill_count %0d, want %0d", cnt, r.fill));
                if (last_flag !== r.last)
                    report($sformatf("last %0d, want %0d", last_flag, r.last));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [CMD_W-1:0]   i_cmd   = CMD_NONE;
    logic [DATA_W-1:0]  i_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [2:0]         o_status;
    logic [IDX_W-1:0]   o_match_index;
    logic [CNT_W-1:0]   o_fill_count;
    logic               o_last;

    table_scoreboard sb;
    bit              idle_on   = 1'b1;
    bit              press_req = 1'b0;
    int              items_sent = 0;

    compacting_array_table #(.DEPTH(TBL_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_match_index (o_match_index),
        .o_fill_count  (o_fill_count),
        .o_last        (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // output side: check every transaction that leaves the block
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_status, o_match_index, o_fill_count, o_last);
        end
    end

    // output back-pressure: random bursts, free runs, and one long hold-off
    initial begin : rx_side
        @(posedge i_clk);
        forever begin
            if (press_req) begin
                press_req = 1'b0;
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_item(input t_cmd cmd, input logic [DATA_W-1:0] value);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(cmd, value);
        if (cmd != CMD_NONE) items_sent++;
    endtask

    // often values already in the table, so deletes and searches hit
    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned roll;
        logic [DATA_W-1:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            v = $urandom;
        end else if (roll < 30) begin
            case ($urandom_range(0, 3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = 32'hffff_ffff;
                default: v = 32'h0000_0000;
            endcase
        end else if (roll < 75 && sb.fill > 0) begin
            v = sb.entries[$urandom_range(0, sb.fill - 1)];
        end else begin
            v = $urandom_range(0, 7);
        end
        return v;
    endfunction

    // delete until empty, then hit the empty table
    task automatic drain_table();
        while (sb.fill > 0) begin
            send_item(CMD_DELETE, sb.entries[$urandom_range(0, sb.fill - 1)]);
        end
        send_item(CMD_DELETE, pick_value());
        send_item(CMD_SEARCH, pick_value());
    endtask

    // append one value until full, overflow once, then search for it
    task automatic fill_table(input logic [DATA_W-1:0] value);
        while (sb.fill < TBL_DEPTH) send_item(CMD_APPEND, value);
        send_item(CMD_APPEND, pick_value());
        send_item(CMD_SEARCH, value);
    endtask

    initial begin : stimulus
        int unsigned roll;
        t_cmd        op;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // preset contents, deletes down to empty, extremes of the value field
        send_item(CMD_SEARCH, 32'd9);
        send_item(CMD_SEARCH, 32'd0);
        send_item(CMD_SEARCH, 32'd7);
        send_item(CMD_NONE,   32'hffff_ffff);
        send_item(CMD_DELETE, 32'd9);
        send_item(CMD_DELETE, 32'd2);
        send_item(CMD_DELETE, 32'd5);
        send_item(CMD_DELETE, 32'd8);
        send_item(CMD_DELETE, 32'd0);
        send_item(CMD_DELETE, 32'd4);
        send_item(CMD_DELETE, 32'd3);
        send_item(CMD_DELETE, 32'd3);
        send_item(CMD_SEARCH, 32'd0);
        send_item(CMD_APPEND, 32'h8000_0000);
        send_item(CMD_APPEND, 32'h7fff_ffff);
        send_item(CMD_APPEND, 32'hffff_ffff);
        send_item(CMD_APPEND, 32'h7fff_ffff);
        send_item(CMD_SEARCH, 32'h7fff_ffff);
        // cleared slots past the fill count must not match
        send_item(CMD_SEARCH, 32'd0);
        send_item(CMD_DELETE, 32'h8000_0000);
        send_item(CMD_NONE,   32'h0000_0000);
        send_item(CMD_SEARCH, 32'hffff_ffff);

        // request one long output hold-off, then drain the table and search a full table of equal values
        press_req = 1'b1;
        drain_table();
        fill_table(pick_value());

        while (items_sent < N_ITEMS) begin
            if (items_sent >= N_ITEMS - 40) idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0: begin
                    drain_table();
                    if ($urandom_range(0, 1) == 1) fill_table(pick_value());
                end
                1: fill_table(pick_value());
                default: begin
                    repeat (8) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 40)      op = CMD_APPEND;
                        else if (roll < 70) op = CMD_DELETE;
                        else if (roll < 95) op = CMD_SEARCH;
                        else                op = CMD_NONE;
                        send_item(op, pick_value());
                    end
                end
            endcase
        end
        idle_on = 1'b0;
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
